// ===== sv/websocket_frame_receiver_assert.svh =====
// assertion macros for the frame receiver parser
`ifndef WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH
`define WEBSOCKET_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, held off during reset
`define WSFR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsfr assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define WSFR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsfr assertion failed: next-cycle implication");

`endif

// ===== sv/wsfr_pkg.sv =====
package wsfr_pkg;

  localparam int LENGTH_BITS_DEF = 64;
  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd10485760;

  // opcodes
  localparam logic [3:0] OP_TEXT      = 4'h1;
  localparam logic [3:0] OP_BINARY    = 4'h2;
  localparam logic [3:0] OP_CLOSE     = 4'h8;
  localparam logic [3:0] OP_PING      = 4'h9;
  localparam logic [3:0] OP_PONG      = 4'hA;
  localparam logic [3:0] OP_LAST_DEF  = 4'hA;

  // short length codes that announce an extended length
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_CLOSE_RCVD  = 3'd1;
  localparam logic [2:0] ST_BAD_UTF8    = 3'd2;
  localparam logic [2:0] ST_UNKNOWN_OP  = 3'd3;
  localparam logic [2:0] ST_INVALID_OP  = 3'd4;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd5;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASKKEY,
    PH_PAYLOAD,
    PH_CLOSED
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       frame_end;
    logic [2:0] status;
    logic       link_closed;
  } wsfr_result_t;

  // status reported when a frame of the given opcode ends
  function automatic logic [2:0] frame_status(input logic [3:0] opcode,
                                              input logic       utf8_bad,
                                              input logic [1:0] utf8_pending);
    logic [2:0] st;
    case (opcode) inside
      OP_TEXT:                    st = (utf8_bad || utf8_pending != 2'd0) ? ST_BAD_UTF8 : ST_OK;
      OP_BINARY, OP_PING, OP_PONG: st = ST_OK;
      OP_CLOSE:                   st = ST_CLOSE_RCVD;
      default:                    st = ST_UNKNOWN_OP;
    endcase
    return st;
  endfunction

endpackage

// ===== sv/websocket_frame_receiver.sv =====
// Byte-serial WebSocket frame receiver for a link already in the open state. One received
// byte is taken per clock whenever in_stall is low; each byte is parsed and, for payload,
// unmasked and UTF-8 checked in the same cycle, and its result is written into the result
// buffer as the byte is taken. Header bytes give no result unless they end a zero-length
// frame or report an error. A two-entry result buffer lets input keep flowing for one
// stalled result; in_stall rises only when both entries hold results. Text, binary and ping
// payload bytes come out with data_valid set and the frame's opcode and FIN bit; close and
// pong payloads are dropped and only their end is reported. The last result of a frame has
// frame_end set and carries the status. Close, unknown or invalid opcodes, oversize lengths
// and bad UTF-8 set link_closed, after which every further byte is taken and ignored.
// cfg_wr_data sets the largest accepted payload length and should be written while idle.
module websocket_frame_receiver #(
  parameter int LENGTH_BITS = wsfr_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_byte,
  output logic        out_data_valid,
  output logic [3:0]  out_frame_opcode,
  output logic        out_final_fragment,
  output logic        out_frame_end,
  output logic [2:0]  out_status,
  output logic        out_link_closed
);

  import wsfr_pkg::*;

  logic         in_accept;
  logic         res_valid;
  wsfr_result_t res;
  wsfr_result_t head;
  logic         buf_full;

  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;

  wsfr_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_accept   (in_accept),
    .rx_byte     (in_rx_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_data_byte      = head.data_byte;
  assign out_data_valid     = head.data_valid;
  assign out_frame_opcode   = head.frame_opcode;
  assign out_final_fragment = head.final_fragment;
  assign out_frame_end      = head.frame_end;
  assign out_status         = head.status;
  assign out_link_closed    = head.link_closed;

endmodule

// ===== sv/wsfr_utf8.sv =====
module wsfr_utf8 (
  input  logic [7:0] data_byte,
  input  logic [1:0] pending,
  input  logic       bad,
  output logic [1:0] pending_nxt,
  output logic       bad_nxt
);

  always_comb begin
    pending_nxt = pending;
    bad_nxt     = bad;
    if (!bad) begin
      if (pending != 2'd0) begin
        if (data_byte[7:6] != 2'b10) begin
          bad_nxt = 1'b1;
        end else begin
          pending_nxt = pending - 2'd1;
        end
      end else if (!data_byte[7]) begin
        // plain ascii
        pending_nxt = 2'd0;
      end else if (data_byte[7:5] == 3'b110) begin
        pending_nxt = 2'd1;
      end else if (data_byte[7:4] == 4'b1110) begin
        pending_nxt = 2'd2;
      end else if (data_byte[7:3] == 5'b11110) begin
        pending_nxt = 2'd3;
      end else begin
        bad_nxt = 1'b1;
      end
    end
  end

endmodule

// ===== sv/wsfr_parser.sv =====
`include "websocket_frame_receiver_assert.svh"

module wsfr_parser #(
  parameter int LENGTH_BITS = wsfr_pkg::LENGTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [31:0]           cfg_wr_data,
  input  logic                  in_accept,
  input  logic [7:0]            rx_byte,
  output logic                  res_valid,
  output wsfr_pkg::wsfr_result_t res
);

  import wsfr_pkg::*;

  localparam int CW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

  logic [31:0]            max_payload_r;
  phase_t                 phase_r, phase_nxt;
  logic [3:0]             opcode_r, opcode_nxt;
  logic                   fin_r, fin_nxt;
  logic                   mask_on_r, mask_on_nxt;
  logic [6:0]             len_code_r, len_code_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [2:0]             hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             key_idx_r, key_idx_nxt;
  logic [1:0]             u_pend_r, u_pend_nxt;
  logic                   u_bad_r, u_bad_nxt;

  logic [7:0]  plain_byte;
  logic [7:0]  key_byte;
  logic [1:0]  key_sel;
  logic [1:0]  feed_pend;
  logic        feed_bad;
  logic        hdr_done;
  logic        emit;
  logic        last;
  logic        delivers;
  logic [2:0]  fin_status;
  logic        fin_closed;
  logic [CW-1:0] rem_ext;
  logic [CW-1:0] max_ext;

  always_comb begin
    key_sel    = 2'd3 - key_idx_r;
    key_byte   = mask_on_r ? key_r[{key_sel, 3'b000} +: 8] : 8'h00;
    plain_byte = rx_byte ^ key_byte;
  end

  wsfr_utf8 u_utf8 (
    .data_byte   (plain_byte),
    .pending     (u_pend_r),
    .bad         (u_bad_r),
    .pending_nxt (feed_pend),
    .bad_nxt     (feed_bad)
  );

  always_comb begin
    phase_nxt    = phase_r;
    opcode_nxt   = opcode_r;
    fin_nxt      = fin_r;
    mask_on_nxt  = mask_on_r;
    len_code_nxt = len_code_r;
    rem_nxt      = rem_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    key_nxt      = key_r;
    key_idx_nxt  = key_idx_r;
    u_pend_nxt   = u_pend_r;
    u_bad_nxt    = u_bad_r;
    hdr_done     = 1'b0;
    emit         = 1'b0;
    last         = 1'b0;
    delivers     = 1'b0;
    fin_status   = ST_OK;
    fin_closed   = 1'b0;
    res          = '0;

    unique case (phase_r)
      PH_HDR0: begin
        opcode_nxt = rx_byte[3:0];
        fin_nxt    = rx_byte[7];
        if (rx_byte[3:0] > OP_LAST_DEF) begin
          phase_nxt       = PH_CLOSED;
          emit            = 1'b1;
          res.frame_end   = 1'b1;
          res.status      = ST_INVALID_OP;
          res.link_closed = 1'b1;
        end else begin
          phase_nxt = PH_HDR1;
        end
      end
      PH_HDR1: begin
        mask_on_nxt  = rx_byte[7];
        len_code_nxt = rx_byte[6:0];
        rem_nxt      = '0;
        if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64) begin
          hdr_cnt_nxt = (rx_byte[6:0] == LEN_EXT16) ? 3'd1 : 3'd7;
          phase_nxt   = PH_EXTLEN;
        end else begin
          rem_nxt = {{(LENGTH_BITS-7){1'b0}}, rx_byte[6:0]};
          if (rx_byte[7]) begin
            hdr_cnt_nxt = 3'd3;
            phase_nxt   = PH_MASKKEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        // saturate once the top byte is occupied
        if (|rem_r[LENGTH_BITS-1 -: 8]) begin
          rem_nxt = '1;
        end else begin
          rem_nxt = {rem_r[LENGTH_BITS-9:0], rx_byte};
        end
        if (hdr_cnt_r != 3'd0) begin
          hdr_cnt_nxt = hdr_cnt_r - 3'd1;
        end else if (mask_on_r) begin
          hdr_cnt_nxt = 3'd3;
          phase_nxt   = PH_MASKKEY;
        end else begin
          hdr_done = 1'b1;
        end
      end
      PH_MASKKEY: begin
        key_nxt = {key_r[23:0], rx_byte};
        if (hdr_cnt_r != 3'd0) begin
          hdr_cnt_nxt = hdr_cnt_r - 3'd1;
        end else begin
          hdr_done = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        key_idx_nxt = key_idx_r + 2'd1;
        if (opcode_r == OP_TEXT) begin
          u_pend_nxt = feed_pend;
          u_bad_nxt  = feed_bad;
        end
        rem_nxt  = rem_r - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
        last     = (rem_r == {{(LENGTH_BITS-1){1'b0}}, 1'b1});
        delivers = (opcode_r == OP_TEXT) || (opcode_r == OP_BINARY) ||
                   (opcode_r == OP_PING);
        if (last) begin
          fin_status = frame_status(opcode_r, u_bad_nxt, u_pend_nxt);
          fin_closed = (fin_status != ST_OK);
          phase_nxt  = fin_closed ? PH_CLOSED : PH_HDR0;
        end
        if (delivers) begin
          emit            = 1'b1;
          res.data_byte   = plain_byte;
          res.data_valid  = 1'b1;
          res.frame_end   = last;
          res.status      = fin_status;
          res.link_closed = fin_closed;
        end else if (last) begin
          emit            = 1'b1;
          res.frame_end   = 1'b1;
          res.status      = fin_status;
          res.link_closed = fin_closed;
        end
      end
      PH_CLOSED: begin
        phase_nxt = PH_CLOSED;
      end
      default: begin
        phase_nxt = PH_CLOSED;
      end
    endcase

    // header complete: length check, then open the payload or end the frame
    rem_ext = {{(CW-LENGTH_BITS){1'b0}}, rem_nxt};
    max_ext = {{(CW-32){1'b0}}, max_payload_r};
    if (hdr_done) begin
      if (rem_ext > max_ext || rem_nxt == {LENGTH_BITS{1'b1}}) begin
        phase_nxt       = PH_CLOSED;
        emit            = 1'b1;
        res.frame_end   = 1'b1;
        res.status      = ST_TOO_LARGE;
        res.link_closed = 1'b1;
      end else begin
        key_idx_nxt = 2'd0;
        u_pend_nxt  = 2'd0;
        u_bad_nxt   = 1'b0;
        if (rem_nxt == '0) begin
          fin_status      = frame_status(opcode_r, 1'b0, 2'd0);
          fin_closed      = (fin_status != ST_OK);
          phase_nxt       = fin_closed ? PH_CLOSED : PH_HDR0;
          emit            = 1'b1;
          res.frame_end   = 1'b1;
          res.status      = fin_status;
          res.link_closed = fin_closed;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
    end

    res.frame_opcode   = opcode_nxt;
    res.final_fragment = fin_nxt;
    res_valid          = in_accept && emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_wr_en) begin
      max_payload_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR0;
      opcode_r   <= '0;
      fin_r      <= 1'b0;
      mask_on_r  <= 1'b0;
      len_code_r <= '0;
      rem_r      <= '0;
      hdr_cnt_r  <= '0;
      key_r      <= '0;
      key_idx_r  <= '0;
      u_pend_r   <= '0;
      u_bad_r    <= 1'b0;
    end else if (in_accept) begin
      phase_r    <= phase_nxt;
      opcode_r   <= opcode_nxt;
      fin_r      <= fin_nxt;
      mask_on_r  <= mask_on_nxt;
      len_code_r <= len_code_nxt;
      rem_r      <= rem_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      key_r      <= key_nxt;
      key_idx_r  <= key_idx_nxt;
      u_pend_r   <= u_pend_nxt;
      u_bad_r    <= u_bad_nxt;
    end
  end

  `WSFR_ASSERT_IMPL(a_closed_quiet, clk, rst_n, phase_r == PH_CLOSED, !res_valid)
  `WSFR_ASSERT_IMPL(a_data_in_payload, clk, rst_n, res_valid && res.data_valid, phase_r == PH_PAYLOAD)
  `WSFR_ASSERT_IMPL(a_err_ends_frame, clk, rst_n, res_valid && res.status != ST_OK, res.frame_end && res.link_closed)
  `WSFR_ASSERT_NEXT(a_close_sticks, clk, rst_n, res_valid && res.link_closed, phase_r == PH_CLOSED)

endmodule

// ===== sv/wsfr_out_buf.sv =====
module wsfr_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  wsfr_pkg::wsfr_result_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  logic                   out_stall,
  output wsfr_pkg::wsfr_result_t head
);

  import wsfr_pkg::*;

  logic         v0_r, v1_r;
  wsfr_result_t e0_r, e1_r;
  logic         pop;

  assign pop       = v0_r && !out_stall;
  assign full      = v1_r;
  assign out_valid = v0_r;
  assign head      = e0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (pop) begin
      if (v1_r) begin
        v1_r <= push;
      end else begin
        v0_r <= push;
      end
    end else if (push) begin
      if (!v0_r) begin
        v0_r <= 1'b1;
      end else begin
        v1_r <= 1'b1;
      end
    end
  end

  // payload side, no reset
  always_ff @(posedge clk) begin
    if (pop) begin
      if (v1_r) begin
        e0_r <= e1_r;
        if (push) begin
          e1_r <= push_data;
        end
      end else if (push) begin
        e0_r <= push_data;
      end
    end else if (push) begin
      if (!v0_r) begin
        e0_r <= push_data;
      end else begin
        e1_r <= push_data;
      end
    end
  end

endmodule

// ===== tb/wsfr_frame_checker.sv =====
module wsfr_frame_checker
  import wsfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_data_byte,
  input  logic        out_data_valid,
  input  logic [3:0]  out_frame_opcode,
  input  logic        out_final_fragment,
  input  logic        out_frame_end,
  input  logic [2:0]  out_status,
  input  logic        out_link_closed,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // the length register saturates at all ones
  localparam logic [63:0] LEN_CEIL = {64{1'b1}} >> (64 - LENGTH_BITS_DEF);

  phase_t      phase;
  logic [3:0]  opcode;
  logic        fin;
  logic        masked;
  logic [6:0]  len_code;
  logic [63:0] len_left;
  logic [2:0]  hdr_left;
  logic [31:0] key;
  logic [1:0]  key_pos;
  logic [1:0]  utf8_need;
  logic        utf8_err;
  logic [31:0] max_len;

  wsfr_result_t owed_results[$];

  function automatic wsfr_result_t pack_result(input logic [7:0] b, input logic v,
                                               input logic e, input logic [2:0] st,
                                               input logic c);
    wsfr_result_t r;
    r.data_byte      = b;
    r.data_valid     = v;
    r.frame_opcode   = opcode;
    r.final_fragment = fin;
    r.frame_end      = e;
    r.status         = st;
    r.link_closed    = c;
    return r;
  endfunction

  // status of the frame that just ended; a nonzero status closes the link
  function automatic logic [2:0] end_status();
    logic [2:0] st;
    case (opcode) inside
      OP_TEXT:                     st = (utf8_err || utf8_need != 2'd0) ? ST_BAD_UTF8 : ST_OK;
      OP_BINARY, OP_PING, OP_PONG: st = ST_OK;
      OP_CLOSE:                    st = ST_CLOSE_RCVD;
      default:                     st = ST_UNKNOWN_OP;
    endcase
    phase = (st != ST_OK) ? PH_CLOSED : PH_HDR0;
    return st;
  endfunction

  function automatic void utf8_take(input logic [7:0] b);
    if (!utf8_err) begin
      if (utf8_need != 2'd0) begin
        if (b[7:6] != 2'b10) utf8_err = 1'b1;
        else utf8_need = utf8_need - 2'd1;
      end else if (b[7:5] == 3'b110) utf8_need = 2'd1;
      else if (b[7:4] == 4'b1110) utf8_need = 2'd2;
      else if (b[7:3] == 5'b11110) utf8_need = 2'd3;
      else if (b[7]) utf8_err = 1'b1;
    end
  endfunction

  function automatic void header_complete(output logic has, output wsfr_result_t r);
    logic [2:0] st;
    has = 1'b0;
    r = '0;
    if (len_left > {32'd0, max_len} || len_left == LEN_CEIL) begin
      phase = PH_CLOSED;
      has = 1'b1;
      r = pack_result(8'h00, 1'b0, 1'b1, ST_TOO_LARGE, 1'b1);
    end else begin
      key_pos = 2'd0;
      utf8_need = 2'd0;
      utf8_err = 1'b0;
      if (len_left == 64'd0) begin
        st = end_status();
        has = 1'b1;
        r = pack_result(8'h00, 1'b0, 1'b1, st, st != ST_OK);
      end else begin
        phase = PH_PAYLOAD;
      end
    end
  endfunction

  function automatic void length_complete(output logic has, output wsfr_result_t r);
    has = 1'b0;
    r = '0;
    if (masked) begin
      hdr_left = 3'd3;
      phase = PH_MASKKEY;
    end else begin
      header_complete(has, r);
    end
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b, output logic has,
                                        output wsfr_result_t r);
    logic [7:0] plain;
    logic [2:0] st;
    logic       is_last;
    has = 1'b0;
    r = '0;
    case (phase)
      PH_HDR0: begin
        opcode = b[3:0];
        fin = b[7];
        if (opcode > OP_LAST_DEF) begin
          phase = PH_CLOSED;
          has = 1'b1;
          r = pack_result(8'h00, 1'b0, 1'b1, ST_INVALID_OP, 1'b1);
        end else begin
          phase = PH_HDR1;
        end
      end
      PH_HDR1: begin
        masked = b[7];
        len_code = b[6:0];
        len_left = 64'd0;
        if (len_code == LEN_EXT16 || len_code == LEN_EXT64) begin
          hdr_left = (len_code == LEN_EXT16) ? 3'd1 : 3'd7;
          phase = PH_EXTLEN;
        end else begin
          len_left = {57'd0, len_code};
          length_complete(has, r);
        end
      end
      PH_EXTLEN: begin
        if (len_left > (LEN_CEIL >> 8)) len_left = LEN_CEIL;
        else len_left = {len_left[55:0], b};
        if (hdr_left != 3'd0) hdr_left = hdr_left - 3'd1;
        else length_complete(has, r);
      end
      PH_MASKKEY: begin
        key = {key[23:0], b};
        if (hdr_left != 3'd0) hdr_left = hdr_left - 3'd1;
        else header_complete(has, r);
      end
      PH_PAYLOAD: begin
        plain = b ^ (masked ? key[8 * (3 - key_pos) +: 8] : 8'h00);
        key_pos = key_pos + 2'd1;
        if (opcode == OP_TEXT) utf8_take(plain);
        len_left = len_left - 64'd1;
        is_last = (len_left == 64'd0);
        st = ST_OK;
        if (is_last) st = end_status();
        if (opcode == OP_TEXT || opcode == OP_BINARY || opcode == OP_PING) begin
          has = 1'b1;
          r = pack_result(plain, 1'b1, is_last, st, st != ST_OK);
        end else if (is_last) begin
          has = 1'b1;
          r = pack_result(8'h00, 1'b0, 1'b1, st, st != ST_OK);
        end
      end
      default: has = 1'b0;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    wsfr_result_t want;
    wsfr_result_t r;
    logic         has;
    if (!rst_n) begin
      phase = PH_HDR0;
      opcode = 4'd0;
      fin = 1'b0;
      masked = 1'b0;
      len_code = 7'd0;
      len_left = 64'd0;
      hdr_left = 3'd0;
      key = 32'd0;
      key_pos = 2'd0;
      utf8_need = 2'd0;
      utf8_err = 1'b0;
      max_len = MAX_PAYLOAD_RST;
      owed_results.delete();
    end else begin
      if (cfg_wr_en) max_len = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          fail_count++;
          $display("%0t: result expected none got byte %0h end %0b status %0d",
                   $time, out_data_byte, out_frame_end, out_status);
        end else begin
          want = owed_results.pop_front();
          check_field("data_byte", want.data_byte, out_data_byte);
          check_field("data_valid", want.data_valid, out_data_valid);
          check_field("frame_opcode", want.frame_opcode, out_frame_opcode);
          check_field("final_fragment", want.final_fragment, out_final_fragment);
          check_field("frame_end", want.frame_end, out_frame_end);
          check_field("status", want.status, out_status);
          check_field("link_closed", want.link_closed, out_link_closed);
        end
      end
      if (in_valid && !in_stall) begin
        parse_rx_byte(in_rx_byte, has, r);
        if (has) owed_results.insert(owed_results.size(), r);
      end
    end
    pending = owed_results.size();
  end

endmodule

// ===== tb/websocket_frame_receiver_tb.sv =====
module websocket_frame_receiver_tb
  import wsfr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [3:0] OP_CONT      = 4'h0;
  localparam logic [3:0] OP_RSV_FIRST = 4'h3;

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_data_byte;
  logic        out_data_valid;
  logic [3:0]  out_frame_opcode;
  logic        out_final_fragment;
  logic        out_frame_end;
  logic [2:0]  out_status;
  logic        out_link_closed;
  int          fail_count;
  int          pending;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_req = 1'b0;
  logic [31:0] cur_max = MAX_PAYLOAD_RST;
  int          bytes_sent = 0;
  int          cycle_count = 0;

  websocket_frame_receiver dut (.*);

  wsfr_frame_checker frame_check (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [3:0] op, input logic [63:0] len,
                             output logic masked, output logic [31:0] key);
    int form;
    masked = 1'($urandom_range(1));
    key = $urandom();
    push_byte({1'($urandom_range(1)), 3'($urandom_range(7)), op});
    if (len <= 64'd125) form = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
    else if (len <= 64'hFFFF) form = $urandom_range(2, 1);
    else form = 2;
    case (form)
      0: push_byte({masked, len[6:0]});
      1: begin
        push_byte({masked, LEN_EXT16});
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
      default: begin
        push_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) push_byte(len[8 * i +: 8]);
      end
    endcase
    if (masked)
      for (int i = 3; i >= 0; i--) push_byte(key[8 * i +: 8]);
  endtask

  task automatic send_frame(input logic [3:0] op, input byte_q_t plain);
    logic        masked;
    logic [31:0] key;
    send_header(op, 64'(plain.size()), masked, key);
    foreach (plain[i])
      push_byte(plain[i] ^ (masked ? key[8 * (3 - i % 4) +: 8] : 8'h00));
  endtask

  // text payloads hold complete utf-8 byte sequences with random bits in them
  function automatic void make_payload(input logic [3:0] op, input int unsigned n,
                                       output byte_q_t q);
    int unsigned k;
    q = {};
    while (q.size() < n) begin
      if (op != OP_TEXT) begin
        q.insert(q.size(), 8'($urandom()));
      end else begin
        k = $urandom_range((n - q.size() < 4) ? n - q.size() : 4, 1);
        case (k)
          1: q.insert(q.size(), {1'b0, 7'($urandom())});
          2: q.insert(q.size(), {3'b110, 5'($urandom())});
          3: q.insert(q.size(), {4'b1110, 4'($urandom())});
          default: q.insert(q.size(), {5'b11110, 3'($urandom())});
        endcase
        repeat (k - 1) q.insert(q.size(), {2'b10, 6'($urandom())});
      end
    end
  endfunction

  function automatic int unsigned pick_len();
    int unsigned cap;
    if (cur_max == 32'd0) return 0;
    cap = (cur_max < 24) ? cur_max : 24;
    if ($urandom_range(15) == 0) return (cur_max < 300) ? cur_max : $urandom_range(300, 126);
    return $urandom_range(cap, 0);
  endfunction

  task automatic set_max_len(input logic [31:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // header bytes leave no result behind, give the parser time to settle
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_max = v;
  endtask

  task automatic run_segment(input int send_pct, input int rcv_pct, input logic [31:0] max_v,
                             input int budget, input bit hold);
    byte_q_t     q;
    logic [3:0]  op;
    int          start;
    set_max_len(max_v);
    send_idle_pct = send_pct;
    stall_pct = rcv_pct;
    if (hold) hold_req <= ~hold_req;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      case ($urandom_range(3))
        0: op = OP_TEXT;
        1: op = OP_BINARY;
        2: op = OP_PING;
        default: op = OP_PONG;
      endcase
      make_payload(op, pick_len(), q);
      send_frame(op, q);
    end
  endtask

  // the link can only be closed once per run, so one closing case is picked at random
  task automatic send_closing_frame();
    byte_q_t     q;
    byte_q_t     tail;
    logic [3:0]  op;
    logic [63:0] big;
    logic        masked;
    logic [31:0] key;
    int unsigned k;
    case ($urandom_range(4))
      0: begin
        make_payload(OP_CLOSE, $urandom_range(8), q);
        send_frame(OP_CLOSE, q);
      end
      1: begin
        k = $urandom_range(5);
        op = (k == 5) ? OP_CONT : OP_RSV_FIRST + 4'(k);
        make_payload(op, $urandom_range(8), q);
        send_frame(op, q);
      end
      2: push_byte({1'($urandom_range(1)), 3'($urandom_range(7)),
                    4'($urandom_range(15, OP_LAST_DEF + 1))});
      3: begin
        case ($urandom_range(2))
          0: big = {32'd0, cur_max} + 64'd1;
          1: big = '1;
          default: big = {$urandom(), $urandom()} | (64'd1 << 63);
        endcase
        send_header($urandom_range(1) ? OP_BINARY : OP_PING, big, masked, key);
      end
      default: begin
        make_payload(OP_TEXT, $urandom_range(6), q);
        case ($urandom_range(2))
          0: q.insert(q.size(), $urandom_range(1) ? {2'b10, 6'($urandom())}
                                                  : {5'b11111, 3'($urandom())});
          1: begin
            // three-byte lead followed by plain ascii
            q.insert(q.size(), {4'b1110, 4'($urandom())});
            q.insert(q.size(), {1'b0, 7'($urandom())});
          end
          default: begin
            q.insert(q.size(), {4'b1110, 4'($urandom())});
            if ($urandom_range(1)) q.insert(q.size(), {2'b10, 6'($urandom())});
          end
        endcase
        // a sequence cut by the frame end needs no tail
        if (q[q.size() - 1][7:6] != 2'b11 && q[q.size() - 1][7:6] != 2'b10) begin
          make_payload(OP_TEXT, $urandom_range(4), tail);
          q = {q, tail};
        end
        send_frame(OP_TEXT, q);
      end
    endcase
    // a closed link swallows everything after
    repeat ($urandom_range(8, 3)) push_byte(8'($urandom()));
  endtask

  initial begin
    byte_q_t warmup;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 32'd0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    warmup = '{
      {1'b1, 3'b000, OP_TEXT}, 8'h00,
      {1'b0, 3'b000, OP_BINARY}, {1'b1, 7'd1}, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
      {1'b1, 3'b000, OP_PING}, 8'h01, 8'hFF,
      {1'b1, 3'b000, OP_PONG}, 8'h00,
      {1'b1, 3'b111, OP_TEXT}, {1'b0, LEN_EXT16}, 8'h00, 8'h02, 8'hC3, 8'hA9,
      {1'b1, 3'b000, OP_BINARY}, {1'b0, LEN_EXT64}, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h01, 8'h55
    };
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (warmup[i]) push_byte(warmup[i]);
    run_segment(0, 0, 32'hFFFF_FFFF, 150, 1'b0);
    run_segment(60, 0, 32'd0, 60, 1'b0);
    run_segment(0, 60, 32'($urandom_range(40, 1)), 180, 1'b1);
    run_segment(27, 27, 32'd1, 60, 1'b0);
    run_segment(27, 27, 32'($urandom_range(200, 20)), 150, 1'b0);
    run_segment(0, 0, MAX_PAYLOAD_RST, 120, 1'b0);
    send_closing_frame();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
